@@ rtl/kmc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kmc_pkg
// Types, codes and the keyword table shared by the keyword match counter.
// ----------------------------------------------------------------------------
package kmc_pkg;

    localparam int CHAR_W        = 8;
    localparam int KEYWORD_COUNT = 32;
    localparam int KW_IDX_W      = $clog2(KEYWORD_COUNT);
    localparam int KW_MAX_LEN    = 8;
    localparam int KW_W          = KW_MAX_LEN * CHAR_W;
    localparam int KW_LEN_W      = 4;
    localparam int HIT_COUNT_W   = 16;

    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_CHAR   = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    typedef enum logic [1:0] {
        KIND_WORD  = 2'd0,
        KIND_ENTRY = 2'd1,
        KIND_EMPTY = 2'd2
    } kmc_kind_t;

    typedef enum logic {
        B_IDLE,
        B_REPORT
    } kmc_back_state_t;

    typedef struct packed {
        logic              op;
        logic [CHAR_W-1:0] char_code;
        logic              word_end;
    } kmc_in_t;

    typedef struct packed {
        kmc_kind_t              kind;
        logic                   hit;
        logic [KW_IDX_W-1:0]    keyword_index;
        logic [HIT_COUNT_W-1:0] hit_count;
        logic                   last;
    } kmc_out_t;

    // One queued command: a finished word (with its match) or a report request.
    typedef struct packed {
        logic                report;
        logic                hit;
        logic [KW_IDX_W-1:0] idx;
    } kmc_cmd_t;

    // Keywords right-justified, first character in the highest used byte.
    localparam logic [KW_W-1:0] KW_TEXT [KEYWORD_COUNT] = '{
        KW_W'("auto"),     KW_W'("break"),   KW_W'("case"),     KW_W'("char"),
        KW_W'("const"),    KW_W'("continue"), KW_W'("default"), KW_W'("do"),
        KW_W'("double"),   KW_W'("else"),    KW_W'("enum"),     KW_W'("extern"),
        KW_W'("float"),    KW_W'("for"),     KW_W'("goto"),     KW_W'("if"),
        KW_W'("int"),      KW_W'("long"),    KW_W'("register"), KW_W'("return"),
        KW_W'("short"),    KW_W'("signed"),  KW_W'("sizeof"),   KW_W'("static"),
        KW_W'("struct"),   KW_W'("switch"),  KW_W'("typedef"),  KW_W'("union"),
        KW_W'("unsigned"), KW_W'("void"),    KW_W'("volatile"), KW_W'("while")
    };

    localparam logic [KW_LEN_W-1:0] KW_LEN [KEYWORD_COUNT] = '{
        4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2,
        4'd6, 4'd4, 4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2,
        4'd3, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd7, 4'd5, 4'd8, 4'd4, 4'd8, 4'd5
    };

endpackage
`default_nettype wire

@@ rtl/kmc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kmc_front
// Collects word characters and matches each finished word against the
// keyword table, queueing one command per finished word or report request.
// ----------------------------------------------------------------------------
module kmc_front
    import kmc_pkg::*;
#(
    parameter int MAX_WORD_CHARS = 9
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire kmc_in_t  req,
    output logic          push,
    output kmc_cmd_t      cmd,
    input  wire logic     full
);

    localparam int LW = $clog2(MAX_WORD_CHARS + 1);

    logic [LW-1:0]   len_reg, len_next;
    logic            too_long_reg, too_long_next;
    logic [KW_W-1:0] word_reg, word_next;

    logic [LW-1:0]            s_len;
    logic                     s_long;
    logic [KW_W-1:0]          s_word;
    logic [KEYWORD_COUNT-1:0] match;
    logic [KW_IDX_W-1:0]      match_idx;
    logic                     accept;

    assign req_ready = !full;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        s_word = word_reg;
        s_len  = len_reg;
        s_long = too_long_reg;
        if (len_reg < LW'(MAX_WORD_CHARS))
        begin
            s_word = {word_reg[KW_W-CHAR_W-1:0], req.char_code};
            s_len  = len_reg + LW'(1);
        end
        else
        begin
            s_long = 1'b1;
        end

        // Keywords are distinct, so at most one bit of match is set.
        match_idx = '0;
        for (int k = 0; k < KEYWORD_COUNT; k++)
        begin
            match[k] = !s_long && (s_len == LW'(KW_LEN[k])) && (s_word == KW_TEXT[k]);
            if (match[k])
            begin
                match_idx = match_idx | KW_IDX_W'(k);
            end
        end
    end

    always_comb
    begin
        len_next      = len_reg;
        too_long_next = too_long_reg;
        word_next     = word_reg;
        if (accept && req.op == OP_CHAR)
        begin
            if (req.word_end)
            begin
                len_next      = '0;
                too_long_next = 1'b0;
                word_next     = '0;
            end
            else
            begin
                len_next      = s_len;
                too_long_next = s_long;
                word_next     = s_word;
            end
        end
    end

    always_comb
    begin
        push       = accept && (req.op == OP_REPORT || req.word_end);
        cmd.report = (req.op == OP_REPORT);
        cmd.hit    = (req.op == OP_CHAR) && (|match);
        cmd.idx    = (req.op == OP_CHAR) ? match_idx : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            too_long_reg <= 1'b0;
            word_reg     <= '0;
        end
        else
        begin
            len_reg      <= len_next;
            too_long_reg <= too_long_next;
            word_reg     <= word_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/kmc_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kmc_queue
// Small command queue between the word matcher and the counter back end.
// ----------------------------------------------------------------------------
module kmc_queue
    import kmc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire kmc_cmd_t wdata,
    output logic          full,
    input  wire logic     pop,
    output kmc_cmd_t      rdata,
    output logic          empty
);

    kmc_cmd_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]  count_reg, count_next;

    assign full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (QUEUE_PTR_W'(rd_ptr_reg + QUEUE_PTR_W'(count_reg)) == wr_ptr_reg))
        else $error("queue pointers disagree with fill count");
`endif

endmodule
`default_nettype wire

@@ rtl/kmc_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kmc_back
// Counter file and result stage: updates counters on hits and walks the
// nonzero counters for a report, one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module kmc_back
    import kmc_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     empty,
    input  wire kmc_cmd_t cmd,
    output logic          pop,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output kmc_out_t      rsp
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    kmc_back_state_t          state_reg, state_next;
    logic [COUNT_BITS-1:0]    cnt_reg [KEYWORD_COUNT];
    logic [KEYWORD_COUNT-1:0] nz_reg, nz_next;
    logic [KEYWORD_COUNT-1:0] rem_reg, rem_next;
    kmc_out_t                 rsp_reg, rsp_next;
    logic                     rsp_valid_reg, rsp_valid_next;

    logic                     load_ok;
    logic [KW_IDX_W-1:0]      low_idx;
    logic [KEYWORD_COUNT-1:0] rem_clear;
    logic [KW_IDX_W-1:0]      rd_idx;
    logic [COUNT_BITS-1:0]    rd_val;
    logic [COUNT_BITS-1:0]    inc_val;
    logic                     cnt_we;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign load_ok   = !rsp_valid_reg || rsp_ready;
    assign pop       = (state_reg == B_IDLE) && !empty && load_ok;

    // Lowest counter still waiting to be reported.
    always_comb
    begin
        low_idx = '0;
        for (int k = KEYWORD_COUNT - 1; k >= 0; k--)
        begin
            if (rem_reg[k])
            begin
                low_idx = KW_IDX_W'(k);
            end
        end
        rem_clear = rem_reg & ~(KEYWORD_COUNT'(1) << low_idx);
    end

    always_comb
    begin
        rd_idx  = (state_reg == B_REPORT) ? low_idx : cmd.idx;
        rd_val  = cnt_reg[rd_idx];
        inc_val = (rd_val == CNT_MAX) ? rd_val : rd_val + COUNT_BITS'(1);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop && cmd.report && nz_reg != '0)
                begin
                    state_next = B_REPORT;
                end
            end
            B_REPORT:
            begin
                if (load_ok && rem_clear == '0)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rem_next       = rem_reg;
        nz_next        = nz_reg;
        cnt_we         = 1'b0;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        unique case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    if (!cmd.report)
                    begin
                        rsp_valid_next         = 1'b1;
                        rsp_next.kind          = KIND_WORD;
                        rsp_next.hit           = cmd.hit;
                        rsp_next.keyword_index = cmd.hit ? cmd.idx : '0;
                        rsp_next.hit_count     = cmd.hit ? HIT_COUNT_W'(inc_val) : '0;
                        rsp_next.last          = 1'b1;
                        if (cmd.hit)
                        begin
                            cnt_we              = 1'b1;
                            nz_next[cmd.idx]    = 1'b1;
                        end
                    end
                    else if (nz_reg == '0)
                    begin
                        rsp_valid_next         = 1'b1;
                        rsp_next.kind          = KIND_EMPTY;
                        rsp_next.hit           = 1'b0;
                        rsp_next.keyword_index = '0;
                        rsp_next.hit_count     = '0;
                        rsp_next.last          = 1'b1;
                    end
                    else
                    begin
                        rem_next = nz_reg;
                    end
                end
            end
            B_REPORT:
            begin
                if (load_ok)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.kind          = KIND_ENTRY;
                    rsp_next.hit           = 1'b0;
                    rsp_next.keyword_index = low_idx;
                    rsp_next.hit_count     = HIT_COUNT_W'(rd_val);
                    rsp_next.last          = (rem_clear == '0);
                    rem_next               = rem_clear;
                end
            end
            default:
            begin
                rem_next = rem_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < KEYWORD_COUNT; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else if (cnt_we)
        begin
            cnt_reg[cmd.idx] <= inc_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            nz_reg        <= '0;
            rem_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nz_reg        <= nz_next;
            rem_reg       <= rem_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_report_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_REPORT) |-> (rem_reg != '0))
        else $error("report walk with no counters left");

    a_nz_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ((nz_reg & $past(nz_reg)) == $past(nz_reg)))
        else $error("nonzero flag of a counter was cleared");

    a_hit_marks_nz: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !cmd.report && cmd.hit) |=> nz_reg[$past(cmd.idx)])
        else $error("counter hit did not mark the counter nonzero");
`endif

endmodule
`default_nettype wire

@@ rtl/c_keyword_match_counter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// c_keyword_match_counter
// Matches words against the 32 C keywords and keeps a saturating hit count
// for each keyword, with a report of all nonzero counts.
// ----------------------------------------------------------------------------
// A character beat is taken every cycle while the four-entry command queue
// has room. The last character of a word is matched in the cycle it is taken;
// its result enters the output register as the back end pops it, so a steady
// stream sustains one word result per cycle unless the output stalls. A report
// latches the nonzero counters, then gives one entry for each as the back end
// walks the counter file one per cycle unless the output stalls; if all are
// zero it gives its single empty marker. Characters keep flowing into the
// front end during a report until the queue fills. Counters clear at reset.
module c_keyword_match_counter
    import kmc_pkg::*;
#(
    parameter int MAX_WORD_CHARS = 9,
    parameter int COUNT_BITS     = 16
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire kmc_in_t  req,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output kmc_out_t      rsp
);

    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_empty;
    kmc_cmd_t q_wdata;
    kmc_cmd_t q_rdata;

    kmc_front #(
        .MAX_WORD_CHARS (MAX_WORD_CHARS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .push      (q_push),
        .cmd       (q_wdata),
        .full      (q_full)
    );

    kmc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    kmc_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .cmd       (q_rdata),
        .pop       (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire
